@@ design/rgbppe_pkg.sv @@
package rgbppe_pkg;

    // effect codes held in the mode register
    typedef enum logic [1:0] {
        MODE_GRAY     = 2'd0,
        MODE_NEGATIVE = 2'd1,
        MODE_XRAY     = 2'd2,
        MODE_AGED     = 2'd3
    } mode_t;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // word index of the mode register (byte address 0)
    localparam logic REG_MODE_IDX = 1'b0;

    // weighted sum 299r + 587g + 114b, below 2^18
    localparam int unsigned SUM_W = 18;
    localparam logic [SUM_W-1:0] GRAY_WT_R = 18'd299;
    localparam logic [SUM_W-1:0] GRAY_WT_G = 18'd587;
    localparam logic [SUM_W-1:0] GRAY_WT_B = 18'd114;

    // divide by 1000: multiply by ceil(2^28 / 1000), exact for sums below 2^18
    localparam int unsigned GRAY_RCP_W = 19;
    localparam int unsigned GRAY_SHIFT = 28;
    localparam int unsigned GRAY_PROD_W = SUM_W + GRAY_RCP_W;
    localparam logic [GRAY_RCP_W-1:0] GRAY_RCP = 19'd268436;

    // warm channel numerator c(255-c) + 25500 - 100c, below 2^15
    localparam int unsigned WARM_W = 15;
    localparam int unsigned WARM_Q_W = 4;
    localparam int unsigned WARM_RCP_W = 19;
    localparam int unsigned WARM_SHIFT = 30;
    localparam int unsigned WARM_PROD_W = WARM_W + WARM_RCP_W;
    // ceil(2^30 / 2550)
    localparam logic [WARM_RCP_W-1:0] WARM_RCP = 19'd421076;

    // blue numerator 2450b - b*b, below 2^20
    localparam int unsigned BLUE_W = 20;
    localparam int unsigned BLUE_RCP_W = 21;
    localparam int unsigned BLUE_SHIFT = 32;
    localparam int unsigned BLUE_PROD_W = BLUE_W + BLUE_RCP_W;
    // ceil(2^32 / 2550)
    localparam logic [BLUE_RCP_W-1:0] BLUE_RCP = 21'd1684301;

    function automatic logic [WARM_W-1:0] warm_num(input logic [CHAN_W-1:0] c);
        logic [15:0] acc;
        begin
            acc = 16'(c) * (16'd255 - 16'(c)) + 16'd25500 - 16'(c) * 16'd100;
            return acc[WARM_W-1:0];
        end
    endfunction

    function automatic logic [BLUE_W-1:0] blue_num(input logic [CHAN_W-1:0] b);
        begin
            return BLUE_W'(b) * (20'd2450 - BLUE_W'(b));
        end
    endfunction

    // floor(g^1.5); from 41 upwards the value passes 255 and saturates
    function automatic logic [CHAN_W-1:0] xray_lut(input logic [CHAN_W-1:0] g);
        logic [CHAN_W-1:0] y;
        begin
            case (g)
                8'd0:  y = 8'd0;
                8'd1:  y = 8'd1;
                8'd2:  y = 8'd2;
                8'd3:  y = 8'd5;
                8'd4:  y = 8'd8;
                8'd5:  y = 8'd11;
                8'd6:  y = 8'd14;
                8'd7:  y = 8'd18;
                8'd8:  y = 8'd22;
                8'd9:  y = 8'd27;
                8'd10: y = 8'd31;
                8'd11: y = 8'd36;
                8'd12: y = 8'd41;
                8'd13: y = 8'd46;
                8'd14: y = 8'd52;
                8'd15: y = 8'd58;
                8'd16: y = 8'd64;
                8'd17: y = 8'd70;
                8'd18: y = 8'd76;
                8'd19: y = 8'd82;
                8'd20: y = 8'd89;
                8'd21: y = 8'd96;
                8'd22: y = 8'd103;
                8'd23: y = 8'd110;
                8'd24: y = 8'd117;
                8'd25: y = 8'd125;
                8'd26: y = 8'd132;
                8'd27: y = 8'd140;
                8'd28: y = 8'd148;
                8'd29: y = 8'd156;
                8'd30: y = 8'd164;
                8'd31: y = 8'd172;
                8'd32: y = 8'd181;
                8'd33: y = 8'd189;
                8'd34: y = 8'd198;
                8'd35: y = 8'd207;
                8'd36: y = 8'd216;
                8'd37: y = 8'd225;
                8'd38: y = 8'd234;
                8'd39: y = 8'd243;
                8'd40: y = 8'd252;
                default: y = 8'd255;
            endcase
            return y;
        end
    endfunction

endpackage

@@ design/rgb_pixel_point_effects.sv @@
// Point effects on an 8-bit RGB pixel stream: grayscale, negative, x-ray (gray raised
// to the power 1.5, saturated) and an aged look, chosen by the mode register at byte
// address 0 of the APB port (reset value grayscale). One pixel is taken and one pixel
// is returned per clock unless the output stalls, through three register stages
// (weighted sum and channel products, reciprocal multipliers for the constant
// divisions, then table look-up, saturation and effect select in the output register).
// The reciprocal multipliers set the depth of the middle stage. The pipeline fills
// bubbles while the output is stalled, so tready only falls when all three stages
// hold a pixel and the sink is not taking one. The end-of-image flag travels on tlast
// alongside its pixel. Change the mode only while no pixel is in flight.
module rgb_pixel_point_effects
    import rgbppe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    // pixel input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [3*CHAN_W-1:0]   s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  s_axis_tlast,  // end_of_image

    // pixel output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*CHAN_W-1:0]   m_axis_tdata,  // red_out, green_out, blue_out
    output logic                  m_axis_tlast   // end_of_image_out
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    mode_t mode_reg;
    logic  mode_wr;

    assign pready  = 1'b1;
    assign mode_wr = psel && penable && pwrite && (paddr[2] == REG_MODE_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_GRAY;
        end
        else if (mode_wr)
        begin
            mode_reg <= mode_t'(pwdata[MODE_W-1:0]);
        end
    end

    // read back: only the mode register answers, the rest read zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MODE_IDX)
        begin
            prdata = APB_DATA_W'(mode_reg);
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when the stage
    // after it loads, so bubbles close up under back-pressure
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic load1, load2, load3;

    assign load3 = !v3_reg || m_axis_tready;
    assign load2 = !v2_reg || load3;
    assign load1 = !v1_reg || load2;

    assign s_axis_tready = load1;
    assign m_axis_tvalid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: weighted sum for gray and numerators for the aged effect
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] in_r, in_g, in_b;

    assign in_r = s_axis_tdata[CHAN_W-1:0];
    assign in_g = s_axis_tdata[2*CHAN_W-1:CHAN_W];
    assign in_b = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];

    logic [CHAN_W-1:0] p1_r_reg, p1_g_reg, p1_b_reg;
    logic              p1_last_reg;
    logic [SUM_W-1:0]  p1_sum_reg,  p1_sum_next;
    logic [WARM_W-1:0] p1_wr_reg,   p1_wr_next;
    logic [WARM_W-1:0] p1_wg_reg,   p1_wg_next;
    logic [BLUE_W-1:0] p1_bn_reg,   p1_bn_next;

    always_comb
    begin
        p1_sum_next = SUM_W'(in_r) * GRAY_WT_R
                    + SUM_W'(in_g) * GRAY_WT_G
                    + SUM_W'(in_b) * GRAY_WT_B;
        p1_wr_next  = warm_num(in_r);
        p1_wg_next  = warm_num(in_g);
        p1_bn_next  = blue_num(in_b);
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            p1_r_reg    <= in_r;
            p1_g_reg    <= in_g;
            p1_b_reg    <= in_b;
            p1_last_reg <= s_axis_tlast;
            p1_sum_reg  <= p1_sum_next;
            p1_wr_reg   <= p1_wr_next;
            p1_wg_reg   <= p1_wg_next;
            p1_bn_reg   <= p1_bn_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: constant divisions as multiply by reciprocal and shift
    // ------------------------------------------------------------------
    logic [GRAY_PROD_W-1:0] gray_prod;
    logic [WARM_PROD_W-1:0] wr_prod, wg_prod;
    logic [BLUE_PROD_W-1:0] bn_prod;

    logic [CHAN_W-1:0]   p2_r_reg, p2_g_reg, p2_b_reg;
    logic                p2_last_reg;
    logic [CHAN_W-1:0]   p2_gray_reg, p2_gray_next;
    logic [WARM_Q_W-1:0] p2_qr_reg,   p2_qr_next;
    logic [WARM_Q_W-1:0] p2_qg_reg,   p2_qg_next;
    logic [CHAN_W-1:0]   p2_qb_reg,   p2_qb_next;

    always_comb
    begin
        gray_prod    = GRAY_PROD_W'(p1_sum_reg) * GRAY_PROD_W'(GRAY_RCP);
        wr_prod      = WARM_PROD_W'(p1_wr_reg) * WARM_PROD_W'(WARM_RCP);
        wg_prod      = WARM_PROD_W'(p1_wg_reg) * WARM_PROD_W'(WARM_RCP);
        bn_prod      = BLUE_PROD_W'(p1_bn_reg) * BLUE_PROD_W'(BLUE_RCP);
        // gray never exceeds 255, warm quotient 12, blue quotient 219
        p2_gray_next = gray_prod[GRAY_SHIFT +: CHAN_W];
        p2_qr_next   = wr_prod[WARM_SHIFT +: WARM_Q_W];
        p2_qg_next   = wg_prod[WARM_SHIFT +: WARM_Q_W];
        p2_qb_next   = bn_prod[BLUE_SHIFT +: CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            p2_r_reg    <= p1_r_reg;
            p2_g_reg    <= p1_g_reg;
            p2_b_reg    <= p1_b_reg;
            p2_last_reg <= p1_last_reg;
            p2_gray_reg <= p2_gray_next;
            p2_qr_reg   <= p2_qr_next;
            p2_qg_reg   <= p2_qg_next;
            p2_qb_reg   <= p2_qb_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: x-ray table, aged saturation and effect select
    // ------------------------------------------------------------------
    logic [CHAN_W:0]   aged_r_sum, aged_g_sum;
    logic [CHAN_W-1:0] aged_r, aged_g, xray_val;

    logic [CHAN_W-1:0] out_r_reg, out_r_next;
    logic [CHAN_W-1:0] out_g_reg, out_g_next;
    logic [CHAN_W-1:0] out_b_reg, out_b_next;
    logic              out_last_reg;

    always_comb
    begin
        xray_val   = xray_lut(p2_gray_reg);
        aged_r_sum = {1'b0, p2_r_reg} + (CHAN_W+1)'(p2_qr_reg);
        aged_g_sum = {1'b0, p2_g_reg} + (CHAN_W+1)'(p2_qg_reg);
        aged_r     = aged_r_sum[CHAN_W] ? {CHAN_W{1'b1}} : aged_r_sum[CHAN_W-1:0];
        aged_g     = aged_g_sum[CHAN_W] ? {CHAN_W{1'b1}} : aged_g_sum[CHAN_W-1:0];

        case (mode_reg)
            MODE_GRAY:
            begin
                out_r_next = p2_gray_reg;
                out_g_next = p2_gray_reg;
                out_b_next = p2_gray_reg;
            end
            MODE_NEGATIVE:
            begin
                out_r_next = ~p2_r_reg;
                out_g_next = ~p2_g_reg;
                out_b_next = ~p2_b_reg;
            end
            MODE_XRAY:
            begin
                out_r_next = xray_val;
                out_g_next = xray_val;
                out_b_next = xray_val;
            end
            default:
            begin
                // aged
                out_r_next = aged_r;
                out_g_next = aged_g;
                out_b_next = p2_qb_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            out_r_reg    <= out_r_next;
            out_g_reg    <= out_g_next;
            out_b_reg    <= out_b_next;
            out_last_reg <= p2_last_reg;
        end
    end

    assign m_axis_tdata = {out_b_reg, out_g_reg, out_r_reg};
    assign m_axis_tlast = out_last_reg;

endmodule

@@ tb/rgb_pixel_point_effects_tb.sv @@
`timescale 1ns / 100ps

module rgb_pixel_point_effects_tb
    import rgbppe_pkg::*;
();

    // pipeline depth of the block, used for settling before a mode change and at the end
    localparam int LATENCY      = 3;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_ITEM = 600;

    // byte address of the mode register
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR = APB_ADDR_W'(4 * int'(REG_MODE_IDX));

    // one pixel as it travels on either stream
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              eoi;
    } pixel_t;

    // one row of the directed table; result is used only where typed is set
    typedef struct {
        mode_t             mode;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              eoi;
        bit                typed;
        logic [CHAN_W-1:0] red_res;
        logic [CHAN_W-1:0] green_res;
        logic [CHAN_W-1:0] blue_res;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [3*CHAN_W-1:0]   s_axis_tdata = '0;   // red_in, green_in, blue_in
    logic                  s_axis_tlast = 1'b0; // end_of_image

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [3*CHAN_W-1:0]   m_axis_tdata;        // red_out, green_out, blue_out
    logic                  m_axis_tlast;        // end_of_image_out

    // testbench copy of the mode register, follows every completed write
    mode_t  effect_mode = MODE_GRAY;
    // transformed pixels still owed by the block, oldest first
    pixel_t pending_pixels[$];
    int     error_count    = 0;
    int     accepted_count = 0;
    int     cycle_count    = 0;
    // sender runs without gaps while this is set
    bit     sender_burst   = 1'b0;

    rgb_pixel_point_effects uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // one line per mismatch, counted for the final verdict
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // floor((299r + 587g + 114b) / 1000)
    function automatic int unsigned luma(input pixel_t p);
        return (299 * int'(p.red) + 587 * int'(p.green) + 114 * int'(p.blue)) / 1000;
    endfunction

    // floor(y^1.5) as the largest root with root^2 <= y^3, clamped at 255
    function automatic int unsigned xray_level(input int unsigned y);
        int unsigned cube;
        int unsigned root;
        cube = y * y * y;
        root = 0;
        while (root < 255 && (root + 1) * (root + 1) <= cube)
            root++;
        return root;
    endfunction

    // red and green of the aged look, saturated
    function automatic int unsigned warm_tone(input int unsigned c);
        int unsigned v;
        v = c + (c * (255 - c) + 25500 - 100 * c) / 2550;
        return (v > 255) ? 255 : v;
    endfunction

    // transformed pixel for the effect held in the mode copy
    function automatic pixel_t apply_effect(input mode_t m, input pixel_t p);
        pixel_t      q;
        int unsigned y;
        q.eoi = p.eoi;
        case (m)
            MODE_GRAY:
            begin
                y = luma(p);
                q.red   = CHAN_W'(y);
                q.green = CHAN_W'(y);
                q.blue  = CHAN_W'(y);
            end
            MODE_NEGATIVE:
            begin
                q.red   = 8'd255 - p.red;
                q.green = 8'd255 - p.green;
                q.blue  = 8'd255 - p.blue;
            end
            MODE_XRAY:
            begin
                y = xray_level(luma(p));
                q.red   = CHAN_W'(y);
                q.green = CHAN_W'(y);
                q.blue  = CHAN_W'(y);
            end
            default:
            begin
                q.red   = CHAN_W'(warm_tone(p.red));
                q.green = CHAN_W'(warm_tone(p.green));
                q.blue  = CHAN_W'((2450 * int'(p.blue) - int'(p.blue) * int'(p.blue)) / 2550);
            end
        endcase
        return q;
    endfunction

    // sender idle length: mostly none or short, now and then long
    function automatic int sender_gap();
        int r;
        if ($urandom_range(0, 49) == 0)
            sender_burst = ~sender_burst;
        if (sender_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // offer one pixel until the block takes it, then idle for a while;
    // stop_after makes tvalid drop before a settle
    task automatic send_pixel(input pixel_t pix, input pixel_t want, input bit stop_after);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix.blue, pix.green, pix.red};
        s_axis_tlast  <= pix.eoi;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // transaction accepted at this edge
        pending_pixels.push_back(want);
        accepted_count++;
        gap = sender_gap();
        if (stop_after && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // apb write: setup then access, register taken at the access edge
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // apb read, data sampled at the completing access edge
    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // let the pipeline drain, then change the effect and read it back
    task automatic settle_and_set_mode(input mode_t m);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] rdata;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
        // junk above the mode field must be ignored
        wdata = $urandom;
        wdata[MODE_W-1:0] = m;
        apb_write(MODE_ADDR, wdata);
        effect_mode = mode_t'(wdata[MODE_W-1:0]);
        apb_read(MODE_ADDR, rdata);
        if (rdata[MODE_W-1:0] != effect_mode)
            report_mismatch($sformatf("mode read back %0d, written %0d",
                                      rdata[MODE_W-1:0], effect_mode));
    endtask

    // random pixel, weighted towards dark values where x-ray is not yet saturated
    // and towards the channel extremes
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            p.red   = $urandom_range(0, 255);
            p.green = $urandom_range(0, 255);
            p.blue  = $urandom_range(0, 255);
        end
        else if (kind < 8)
        begin
            p.red   = $urandom_range(0, 50);
            p.green = $urandom_range(0, 50);
            p.blue  = $urandom_range(0, 50);
        end
        else if (kind == 8)
        begin
            p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        else
        begin
            p.red   = $urandom_range(200, 255);
            p.green = $urandom_range(200, 255);
            p.blue  = $urandom_range(200, 255);
        end
        p.eoi = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    // directed table: reset mode first, then every effect at the channel extremes
    dir_row_t dir_rows [0:19] = '{
        // grayscale straight after reset
        '{MODE_GRAY,     8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        '{MODE_GRAY,     8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255},
        '{MODE_GRAY,     8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{MODE_GRAY,     8'd0,   8'd255, 8'd0,   1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{MODE_GRAY,     8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        // negative
        '{MODE_NEGATIVE, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd255, 8'd255, 8'd255},
        '{MODE_NEGATIVE, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        '{MODE_NEGATIVE, 8'h55,  8'hAA,  8'h0F,  1'b1, 1'b1, 8'hAA,  8'h55,  8'hF0},
        // x-ray: zero gray, full white, the edge of saturation, gray of one, a mixed pixel
        '{MODE_XRAY,     8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
        '{MODE_XRAY,     8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255},
        '{MODE_XRAY,     8'd40,  8'd40,  8'd40,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{MODE_XRAY,     8'd41,  8'd41,  8'd41,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        '{MODE_XRAY,     8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{MODE_XRAY,     8'd90,  8'd12,  8'd200, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        // aged look
        '{MODE_AGED,     8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd10,  8'd10,  8'd0},
        '{MODE_AGED,     8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 8'd219},
        '{MODE_AGED,     8'd128, 8'd200, 8'd100, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{MODE_AGED,     8'd245, 8'd250, 8'd1,   1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
        // back to grayscale
        '{MODE_GRAY,     8'd7,   8'd123, 8'd201, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
        '{MODE_GRAY,     8'd254, 8'd1,   8'd128, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    // order of the random phases; the last one draws its effect at random
    mode_t phase_modes [0:7] = '{MODE_AGED, MODE_XRAY, MODE_GRAY, MODE_NEGATIVE,
                                 MODE_AGED, MODE_GRAY, MODE_XRAY, MODE_NEGATIVE};

    // stimulus
    initial
    begin
        pixel_t pix;
        pixel_t want;
        bit     stop_after;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the first rows run on the reset value of the mode register
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mode != effect_mode)
                settle_and_set_mode(dir_rows[i].mode);
            pix = '{dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue, dir_rows[i].eoi};
            if (dir_rows[i].typed)
                want = '{dir_rows[i].red_res, dir_rows[i].green_res, dir_rows[i].blue_res,
                         dir_rows[i].eoi};
            else
                want = apply_effect(effect_mode, pix);
            stop_after = (i == 19) || (dir_rows[i + 1].mode != dir_rows[i].mode);
            send_pixel(pix, want, stop_after);
        end

        // random phases, one effect each, mode rewritten between them
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                settle_and_set_mode(mode_t'($urandom_range(0, 3)));
            else
                settle_and_set_mode(phase_modes[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pix = random_pixel();
                send_pixel(pix, apply_effect(effect_mode, pix), n == PHASE_ITEMS - 1);
            end
        end

        // drain, then wait on to catch anything extra from the pipeline
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("rgb_pixel_point_effects_tb: PASS");
        else
            $display("rgb_pixel_point_effects_tb: FAIL");
        $finish;
    end

    // sink: random stalls, long ready stretches, and one long hold-off so that
    // the three stages fill up and the block stalls its input
    initial
    begin
        int  r;
        int  run;
        bit  ready;
        bit  held_off;
        held_off = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && accepted_count >= HOLD_AT_ITEM)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    ready = 1'b1;
                    run   = $urandom_range(50, 150);
                end
                else if (r < 60)
                begin
                    ready = 1'b1;
                    run   = $urandom_range(1, 8);
                end
                else if (r < 90)
                begin
                    ready = 1'b0;
                    run   = $urandom_range(1, 3);
                end
                else
                begin
                    ready = 1'b0;
                    run   = $urandom_range(8, 30);
                end
                m_axis_tready <= ready;
                repeat (run) @(posedge clk);
            end
        end
    end

    // output checker: every transaction on the master side against the oldest owed pixel
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[CHAN_W-1:0], m_axis_tdata[2*CHAN_W-1:CHAN_W],
                    m_axis_tdata[3*CHAN_W-1:2*CHAN_W], m_axis_tlast};
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0d",
                                          got.red, got.green, got.blue, got.eoi));
            else
            begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("red_out %0d, expected %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green_out %0d, expected %0d",
                                              got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue_out %0d, expected %0d",
                                              got.blue, want.blue));
                if (got.eoi !== want.eoi)
                    report_mismatch($sformatf("end_of_image_out %0d, expected %0d",
                                              got.eoi, want.eoi));
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rgb_pixel_point_effects_tb: FAIL");
            $finish;
        end
    end

endmodule
